@@ sv/geometry_matrix_stack_core_defines.svh @@
// ---------------------------------------------------------------------------
// geometry matrix stack core defines
// assertion macros used by the matrix stack core
// ---------------------------------------------------------------------------
`ifndef GEOMETRY_MATRIX_STACK_CORE_DEFINES_SVH
`define GEOMETRY_MATRIX_STACK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define GMSK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gmsk: same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define GMSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gmsk: next-cycle check failed");
`else
`define GMSK_ASSERT_SAME(label, clk, rst, ante, cons)
`define GMSK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/gmsk_pkg.sv @@
// ---------------------------------------------------------------------------
// gmsk_pkg
// shared types, codes and helpers of the matrix stack
// ---------------------------------------------------------------------------
package gmsk_pkg;

   localparam int WORD_W           = 4;
   localparam int WORDS_PER_MATRIX = 16;
   localparam int PTR_W            = 5;
   localparam int DATA_W           = 32;
   localparam int MODE_W           = 2;
   localparam int AMOUNT_W         = 6;
   localparam int PTR_CALC_W       = 8;
   localparam int CSR_INDEX_W      = 4;
   localparam int CSR_DATA_W       = 8;

   localparam logic [WORD_W-1:0] LAST_WORD   = 4'd15;
   localparam logic [DATA_W-1:0] ONE_BITS    = 32'h3F80_0000;
   localparam logic [MODE_W-1:0] MODE_RESET  = 2'd1;
   localparam logic [PTR_W-1:0]  LIMIT_RESET = 5'd31;

   // modes that pin the stack to slot zero
   localparam logic [MODE_W-1:0] MODE_SLOT0_LOW  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLOT0_HIGH = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_MODE  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_LIMIT = 4'd1;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_LOAD = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EMIT  = 2'd2
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] index;
      logic              last;
      logic              error;
      logic [PTR_W-1:0]  pointer;
   } rsp_meta_type;

   // identity matrix: ones on the diagonal words 0, 5, 10, 15
   function automatic logic [DATA_W-1:0] identity_word(input logic [WORD_W-1:0] idx);
      return (idx[1:0] == idx[3:2]) ? ONE_BITS : '0;
   endfunction

   function automatic logic uses_slot0(input logic [MODE_W-1:0] mode);
      return (mode == MODE_SLOT0_LOW) || (mode == MODE_SLOT0_HIGH);
   endfunction

endpackage

@@ sv/gmsk_if.sv @@
// ---------------------------------------------------------------------------
// gmsk channel interfaces
// command, result and register write channels of the matrix stack
// ---------------------------------------------------------------------------
interface gmsk_req_if;
   import gmsk_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [WORD_W-1:0]          word_index;
   logic [DATA_W-1:0]          word_value;
   logic signed [AMOUNT_W-1:0] pop_amount;
   logic [PTR_W-1:0]           slot_number;

   modport source (output valid, op, word_index, word_value, pop_amount, slot_number,
                   input ready);
   modport sink   (input valid, op, word_index, word_value, pop_amount, slot_number,
                   output ready);
endinterface

interface gmsk_rsp_if;
   import gmsk_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_word;
   logic [WORD_W-1:0] out_index;
   logic              last_word;
   logic              stack_error;
   logic [PTR_W-1:0]  stack_pointer_out;

   modport source (output valid, out_word, out_index, last_word, stack_error,
                   stack_pointer_out, input ready);
   modport sink   (input valid, out_word, out_index, last_word, stack_error,
                   stack_pointer_out, output ready);
endinterface

interface gmsk_csr_if;
   import gmsk_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/gmsk_store.sv @@
// ---------------------------------------------------------------------------
// gmsk_store
// matrix word memory: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module gmsk_store #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                                         clock,
   input  gmsk_pkg::mem_ctl_type                        mem_ctl,
   input  logic [$clog2(SLOT_COUNT)+gmsk_pkg::WORD_W-1:0] wr_addr,
   input  logic [$clog2(SLOT_COUNT)+gmsk_pkg::WORD_W-1:0] rd_addr,
   input  logic [gmsk_pkg::DATA_W-1:0]                  wr_data,
   output logic [gmsk_pkg::DATA_W-1:0]                  rd_data
);
   import gmsk_pkg::*;

   localparam int DEPTH = SLOT_COUNT * WORDS_PER_MATRIX;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/gmsk_ctrl.sv @@
// ---------------------------------------------------------------------------
// gmsk_ctrl
// command sequencer: clearing pass, pointer and error state, word run reads
// ---------------------------------------------------------------------------
module gmsk_ctrl #(
   parameter int SLOT_COUNT = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   gmsk_req_if.sink                                     req_ch,
   gmsk_csr_if.sink                                     csr_ch,
   input  logic                                         rsp_ready,
   output gmsk_pkg::mem_ctl_type                        mem_ctl,
   output logic [$clog2(SLOT_COUNT)+gmsk_pkg::WORD_W-1:0] wr_addr,
   output logic [$clog2(SLOT_COUNT)+gmsk_pkg::WORD_W-1:0] rd_addr,
   output logic [gmsk_pkg::DATA_W-1:0]                  wr_data,
   output gmsk_pkg::rsp_meta_type                       rsp_meta
);
   import gmsk_pkg::*;

   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int ADDR_W     = SLOT_W + WORD_W;
   localparam int DEPTH      = SLOT_COUNT * WORDS_PER_MATRIX;
   localparam int SLOT_CODES = 2 ** PTR_W;

   state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              err_ff, err_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [PTR_W-1:0]  limit_ff, limit_in;
   logic [SLOT_W-1:0] emit_slot_ff, emit_slot_in;
   logic [WORD_W-1:0] emit_cnt_ff, emit_cnt_in;
   rsp_meta_type      meta_ff, meta_in;

   logic [SLOT_W-1:0] slot_map [SLOT_CODES];

   op_type                       op;
   logic                         accept;
   logic                         advance;
   logic                         clr_done;
   logic                         emit_done;
   logic signed [PTR_CALC_W-1:0] amount_ext;
   logic signed [PTR_CALC_W-1:0] delta;
   logic signed [PTR_CALC_W-1:0] moved;
   logic                         move_err;
   logic                         move_en;
   logic [PTR_W-1:0]             new_ptr;
   logic [SLOT_W-1:0]            push_slot;
   logic [SLOT_W-1:0]            pop_slot;

   // slot code to store slot, wraps codes beyond the store
   for (genvar gi = 0; gi < SLOT_CODES; gi++) begin : g_slot_map
      assign slot_map[gi] = SLOT_W'(gi % SLOT_COUNT);
   end

   // handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.op);
   assign advance      = !meta_ff.valid || rsp_ready;
   assign clr_done     = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign emit_done    = (emit_cnt_ff == LAST_WORD);

   // pointer move: +1 on a finished push, minus the amount on a pop
   assign amount_ext = PTR_CALC_W'(req_ch.pop_amount);
   assign delta      = (op == OP_POP) ? -amount_ext : PTR_CALC_W'(1);
   assign moved      = signed'(PTR_CALC_W'(ptr_ff)) + delta;
   assign move_err   = (moved < 0) || (moved > signed'(PTR_CALC_W'(limit_ff)));
   assign new_ptr    = moved[PTR_W-1:0] & limit_ff;
   assign move_en    = accept && ((op == OP_POP) ||
                       ((op == OP_PUSH) && (req_ch.word_index == LAST_WORD)));

   assign push_slot = uses_slot0(mode_ff) ? '0 : slot_map[ptr_ff];
   assign pop_slot  = uses_slot0(mode_ff) ? '0 : slot_map[new_ptr];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && ((op == OP_POP) || (op == OP_READ))) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (advance && emit_done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // memory port controls
   always_comb begin
      mem_ctl = '0;
      wr_addr = clr_cnt_ff;
      wr_data = identity_word(clr_cnt_ff[WORD_W-1:0]);
      rd_addr = {emit_slot_ff, emit_cnt_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_PUSH: begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = {push_slot, req_ch.word_index};
                     wr_data       = req_ch.word_value;
                  end
                  OP_LOAD: begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = {slot_map[req_ch.slot_number], req_ch.word_index};
                     wr_data       = req_ch.word_value;
                  end
                  OP_POP, OP_READ: begin
                     mem_ctl.wr_en = 1'b0;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            mem_ctl.rd_en = advance;
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   // register next values
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      ptr_in       = ptr_ff;
      err_in       = err_ff;
      mode_in      = mode_ff;
      limit_in     = limit_ff;
      emit_slot_in = emit_slot_ff;
      emit_cnt_in  = emit_cnt_ff;
      meta_in      = meta_ff;

      if (state_ff == ST_CLEAR) clr_cnt_in = ADDR_W'(clr_cnt_ff + 1'b1);

      if (move_en) begin
         ptr_in = new_ptr;
         err_in = err_ff | move_err;
      end

      if (accept) begin
         emit_slot_in = (op == OP_POP) ? pop_slot : slot_map[req_ch.slot_number];
         emit_cnt_in  = '0;
      end

      // result register: load on each issued read, drain on transfer
      if ((state_ff == ST_EMIT) && advance) begin
         emit_cnt_in     = WORD_W'(emit_cnt_ff + 1'b1);
         meta_in.valid   = 1'b1;
         meta_in.index   = emit_cnt_ff;
         meta_in.last    = emit_done;
         meta_in.error   = err_ff;
         meta_in.pointer = ptr_ff;
      end else if (rsp_ready) begin
         meta_in.valid = 1'b0;
      end

      // register writes, other indexes are ignored
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_STACK_MODE: begin
               mode_in = csr_ch.data[MODE_W-1:0];
            end
            CSR_STACK_LIMIT: begin
               limit_in = csr_ch.data[PTR_W-1:0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         ptr_ff        <= '0;
         err_ff        <= 1'b0;
         mode_ff       <= MODE_RESET;
         limit_ff      <= LIMIT_RESET;
         meta_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         ptr_ff        <= ptr_in;
         err_ff        <= err_in;
         mode_ff       <= mode_in;
         limit_ff      <= limit_in;
         meta_ff.valid <= meta_in.valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      emit_slot_ff    <= emit_slot_in;
      emit_cnt_ff     <= emit_cnt_in;
      meta_ff.index   <= meta_in.index;
      meta_ff.last    <= meta_in.last;
      meta_ff.error   <= meta_in.error;
      meta_ff.pointer <= meta_in.pointer;
   end

   assign rsp_meta = meta_ff;

endmodule

@@ sv/geometry_matrix_stack_core.sv @@
// ---------------------------------------------------------------------------
// geometry_matrix_stack_core
// stack of 4x4 matrices kept as 32-bit words in one synchronous memory
//
// channel  dir  transfer carries
// req_ch   in   op, word_index, word_value, pop_amount, slot_number
// rsp_ch   out  out_word, out_index, last_word, stack_error, stack_pointer_out
// csr_ch   in   register index and write data (stack_mode, stack_limit)
//
// push and load are written when taken and may follow back to back.
// pop and read first latch the command, then issue one memory read per word
// into the result register, 16 words on the single read port.
// after reset a clearing pass writes identity matrices to all SLOT_COUNT*16
// words (512 by default); no command is taken until it ends.
// a stalled result holds the read port; the next command is taken while the
// last word of a run still waits.
// ---------------------------------------------------------------------------
`include "geometry_matrix_stack_core_defines.svh"

module geometry_matrix_stack_core #(
   parameter int SLOT_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   gmsk_req_if.sink    req_ch,
   gmsk_rsp_if.source  rsp_ch,
   gmsk_csr_if.sink    csr_ch
);
   import gmsk_pkg::*;

   localparam int ADDR_W = $clog2(SLOT_COUNT) + WORD_W;

   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] rd_data;
   rsp_meta_type      rsp_meta;
   logic              mid_run;
   logic              run_word;
   logic              err_seen;
   logic [WORD_W:0]   run_next;
   logic [WORD_W:0]   run_want;

   // sequencer
   gmsk_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .rsp_ready (rsp_ch.ready),
      .mem_ctl   (mem_ctl),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .wr_data   (wr_data),
      .rsp_meta  (rsp_meta)
   );

   // matrix memory
   gmsk_store #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // result channel
   assign rsp_ch.valid             = rsp_meta.valid;
   assign rsp_ch.out_word          = rd_data;
   assign rsp_ch.out_index         = rsp_meta.index;
   assign rsp_ch.last_word         = rsp_meta.last;
   assign rsp_ch.stack_error       = rsp_meta.error;
   assign rsp_ch.stack_pointer_out = rsp_meta.pointer;

   // terms for the checks below
   assign mid_run  = rsp_ch.valid && !rsp_ch.last_word;
   assign run_word = mid_run && rsp_ch.ready;
   assign err_seen = rsp_ch.valid && rsp_ch.stack_error;
   assign run_next = {rsp_ch.valid, rsp_ch.out_index};
   assign run_want = {1'b1, WORD_W'(rsp_ch.out_index + 1'b1)};

   // no command is taken in the middle of a word run
   `GMSK_ASSERT_SAME(a_no_req_mid_run, clock, reset, mid_run, !req_ch.ready)
   // words of a run come in order with no gap
   `GMSK_ASSERT_NEXT(a_run_in_order, clock, reset, run_word, run_next == $past(run_want))
   // the error flag never clears once reported
   `GMSK_ASSERT_NEXT(a_error_sticky, clock, reset, err_seen, !rsp_ch.valid || rsp_ch.stack_error)

endmodule

@@ tb/geometry_matrix_stack_core_tb.sv @@
// ---------------------------------------------------------------------------
// geometry_matrix_stack_core_tb
// self-checking bench for the matrix stack: commands go in over the request
// channel, a shadow copy of the store, pointer and error flag predicts every
// result word, and each word leaving the result channel is compared field by
// field against the oldest prediction. both channels idle at random, and the
// result side holds off once for a long stretch so the core backs up
// ---------------------------------------------------------------------------
module geometry_matrix_stack_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gmsk_pkg::*;

   localparam int SLOTS          = 32;
   localparam int SETTLE_CYCLES  = 24;
   localparam int STALL_CYCLES   = 160;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = '1;
   localparam logic [MODE_W-1:0]      MODE_POINTER_ALT = 2'd2;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   word_index;
      logic [DATA_W-1:0]   word_value;
      logic [AMOUNT_W-1:0] pop_amount;
      logic [PTR_W-1:0]    slot_number;
   } stack_cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic [WORD_W-1:0] index;
      logic              last;
      logic              error;
      logic [PTR_W-1:0]  pointer;
   } matrix_word_type;

   logic clock;
   logic reset;

   gmsk_req_if req_ch();
   gmsk_rsp_if rsp_ch();
   gmsk_csr_if csr_ch();

   geometry_matrix_stack_core #(.SLOT_COUNT(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the stack state
   logic [DATA_W-1:0] shadow_mem [SLOTS*WORDS_PER_MATRIX];
   logic [PTR_W-1:0]  shadow_ptr;
   logic              shadow_err;
   logic [MODE_W-1:0] shadow_mode;
   logic [PTR_W-1:0]  shadow_limit;
   matrix_word_type   pending_words [$];
   matrix_word_type   rsp_want;

   int   fault_count  = 0;
   int   cmd_count    = 0;
   int   req_calm     = 0;
   int   rsp_calm     = 0;
   int   rsp_wait     = 0;
   int   rsp_hold     = 0;
   int   quiet_cycles = 0;
   bit   req_no_gaps  = 1'b0;
   logic stall_pulse;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // idle cycles for one transfer, with occasional stretches of none
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic void check_field(input string field, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", field, want, got);
         fault_count++;
      end
   endfunction

   // slot that push and pop address
   function automatic int top_slot();
      if (shadow_mode == MODE_SLOT0_LOW || shadow_mode == MODE_SLOT0_HIGH)
         return 0;
      return int'(shadow_ptr);
   endfunction

   // signed pointer move with sticky range error and limit mask
   function automatic void shadow_move(input int delta);
      int moved;
      moved = int'(shadow_ptr) + delta;
      if (moved < 0 || moved > int'(shadow_limit))
         shadow_err = 1'b1;
      shadow_ptr = moved[PTR_W-1:0] & shadow_limit;
   endfunction

   // the sixteen words a pop or read sends out
   function automatic void queue_frame(input int slot);
      int              base;
      matrix_word_type w;
      base = (slot % SLOTS) * WORDS_PER_MATRIX;
      for (int k = 0; k < WORDS_PER_MATRIX; k++) begin
         w.word    = shadow_mem[base + k];
         w.index   = k[WORD_W-1:0];
         w.last    = (k == WORDS_PER_MATRIX - 1);
         w.error   = shadow_err;
         w.pointer = shadow_ptr;
         pending_words.push_back(w);
      end
   endfunction

   function automatic void predict_command(input stack_cmd_type cmd);
      case (cmd.op)
         OP_PUSH: begin
            shadow_mem[top_slot() * WORDS_PER_MATRIX + int'(cmd.word_index)] = cmd.word_value;
            if (cmd.word_index == LAST_WORD)
               shadow_move(1);
         end
         OP_POP: begin
            shadow_move(-int'($signed(cmd.pop_amount)));
            queue_frame(top_slot());
         end
         OP_LOAD: begin
            shadow_mem[(int'(cmd.slot_number) % SLOTS) * WORDS_PER_MATRIX
                       + int'(cmd.word_index)] = cmd.word_value;
         end
         default: begin
            queue_frame(int'(cmd.slot_number));
         end
      endcase
   endfunction

   function automatic stack_cmd_type random_cmd();
      stack_cmd_type cmd;
      cmd.op          = op_type'($urandom_range(0, 3));
      cmd.word_index  = WORD_W'($urandom_range(0, 15));
      cmd.word_value  = $urandom;
      cmd.pop_amount  = AMOUNT_W'($urandom_range(0, 63));
      cmd.slot_number = PTR_W'($urandom_range(0, SLOTS - 1));
      return cmd;
   endfunction

   // one command transfer; valid stays high afterwards for back to back use
   task automatic send_cmd(input stack_cmd_type cmd);
      int gap;
      gap = req_no_gaps ? 0 : draw_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= cmd.op;
      req_ch.word_index  <= cmd.word_index;
      req_ch.word_value  <= cmd.word_value;
      req_ch.pop_amount  <= cmd.pop_amount;
      req_ch.slot_number <= cmd.slot_number;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_command(cmd);
      cmd_count++;
   endtask

   task automatic push_word(input int idx, input logic [DATA_W-1:0] value);
      stack_cmd_type cmd;
      cmd            = random_cmd();
      cmd.op         = OP_PUSH;
      cmd.word_index = idx[WORD_W-1:0];
      cmd.word_value = value;
      send_cmd(cmd);
   endtask

   task automatic pop_frame(input int amount);
      stack_cmd_type cmd;
      cmd            = random_cmd();
      cmd.op         = OP_POP;
      cmd.pop_amount = amount[AMOUNT_W-1:0];
      send_cmd(cmd);
   endtask

   task automatic load_word(input int slot, input int idx, input logic [DATA_W-1:0] value);
      stack_cmd_type cmd;
      cmd             = random_cmd();
      cmd.op          = OP_LOAD;
      cmd.slot_number = slot[PTR_W-1:0];
      cmd.word_index  = idx[WORD_W-1:0];
      cmd.word_value  = value;
      send_cmd(cmd);
   endtask

   task automatic read_frame(input int slot);
      stack_cmd_type cmd;
      cmd             = random_cmd();
      cmd.op          = OP_READ;
      cmd.slot_number = slot[PTR_W-1:0];
      send_cmd(cmd);
   endtask

   // drop valid, drain every pending word, then let trailing writes land
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write while idle; unused upper data bits are random
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int value);
      logic [CSR_DATA_W-1:0] data;
      settle();
      data = CSR_DATA_W'($urandom);
      if (index == CSR_STACK_MODE)
         data[MODE_W-1:0] = value[MODE_W-1:0];
      else if (index == CSR_STACK_LIMIT)
         data[PTR_W-1:0] = value[PTR_W-1:0];
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (index == CSR_STACK_MODE)
         shadow_mode = data[MODE_W-1:0];
      else if (index == CSR_STACK_LIMIT)
         shadow_limit = data[PTR_W-1:0];
   endtask

   // identity matrices and the pointer right after the clearing pass
   task automatic test_reset_state();
      read_frame(0);
      read_frame(SLOTS - 1);
      pop_frame(0);
   endtask

   // partial push out of order with a repeated word, then load and read extremes
   task automatic test_push_and_load();
      push_word(0, 32'hFFFF_FFFF);
      push_word(3, 32'hAAAA_AAAA);
      push_word(0, 32'h5555_5555);
      push_word(int'(LAST_WORD), 32'h0000_0000);
      pop_frame(1);
      load_word(SLOTS - 1, 0, 32'hFFFF_FFFF);
      load_word(SLOTS - 1, int'(LAST_WORD), 32'h0000_0000);
      load_word(0, 7, 32'h8000_0001);
      read_frame(SLOTS - 1);
      read_frame(0);
   endtask

   // slot-zero modes, lowered limit below the pointer, unused register index
   task automatic test_modes_and_limit();
      write_csr(CSR_STACK_MODE, int'(MODE_SLOT0_LOW));
      push_word(int'(LAST_WORD), 32'h1234_5678);
      pop_frame(-2);
      write_csr(CSR_STACK_MODE, int'(MODE_SLOT0_HIGH));
      pop_frame(0);
      write_csr(CSR_STACK_MODE, int'(MODE_POINTER_ALT));
      push_word(5, 32'hDEAD_BEEF);
      pop_frame(0);
      write_csr(CSR_STACK_LIMIT, 1);
      read_frame(3);
      write_csr(CSR_SPARE_INDEX, 255);
      write_csr(CSR_STACK_LIMIT, int'(LIMIT_RESET));
      write_csr(CSR_STACK_MODE, int'(MODE_RESET));
      read_frame(5);
   endtask

   // well-formed push, pop, load and read traffic that keeps the pointer in range
   task automatic test_stack_frames();
      int stop_at;
      int order [WORDS_PER_MATRIX];
      int pick;
      int swap_at;
      int tmp;
      int lo;
      int hi;
      int words;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_STACK_MODE, int'(MODE_RESET));
               write_csr(CSR_STACK_LIMIT, int'(LIMIT_RESET));
            end
            1: begin
               write_csr(CSR_STACK_MODE, int'(MODE_POINTER_ALT));
               write_csr(CSR_STACK_LIMIT, $urandom_range(4, 30));
            end
            2: begin
               write_csr(CSR_STACK_MODE, int'(MODE_SLOT0_LOW));
               write_csr(CSR_STACK_LIMIT, int'(LIMIT_RESET));
            end
            default: begin
               write_csr(CSR_STACK_MODE, int'(MODE_SLOT0_HIGH));
               write_csr(CSR_STACK_LIMIT, $urandom_range(2, 31));
            end
         endcase
         stop_at = cmd_count + 45;
         while (cmd_count < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 5 && shadow_ptr < shadow_limit) begin
               // shuffled frame; a short one leaves out the closing word
               for (int k = 0; k < WORDS_PER_MATRIX; k++)
                  order[k] = k;
               for (int k = WORDS_PER_MATRIX - 2; k > 0; k--) begin
                  swap_at        = $urandom_range(0, k);
                  tmp            = order[k];
                  order[k]       = order[swap_at];
                  order[swap_at] = tmp;
               end
               words = (pick == 0) ? $urandom_range(1, 14) : WORDS_PER_MATRIX - 1;
               for (int k = 0; k < words; k++)
                  push_word(order[k], $urandom);
               if (pick != 0)
                  push_word(int'(LAST_WORD), $urandom);
            end else if (pick < 8) begin
               lo = int'(shadow_ptr) - int'(shadow_limit);
               hi = int'(shadow_ptr);
               pop_frame(lo + int'($urandom_range(0, hi - lo)));
            end else if (pick == 8) begin
               load_word($urandom_range(0, SLOTS - 1), $urandom_range(0, 15), $urandom);
            end else begin
               read_frame($urandom_range(0, SLOTS - 1));
            end
         end
      end
   endtask

   // underflow, overflow with the most negative amount, push past a zero limit
   task automatic test_stack_errors();
      write_csr(CSR_STACK_MODE, int'(MODE_RESET));
      write_csr(CSR_STACK_LIMIT, int'(LIMIT_RESET));
      pop_frame(int'(shadow_ptr));
      pop_frame(1);
      pop_frame(-32);
      pop_frame(31);
      write_csr(CSR_STACK_LIMIT, 0);
      push_word(int'(LAST_WORD), $urandom);
      read_frame(0);
   endtask

   // result side holds off while commands keep coming back to back
   task automatic test_output_stall();
      write_csr(CSR_STACK_LIMIT, int'(LIMIT_RESET));
      stall_pulse <= 1'b1;
      @(posedge clock);
      stall_pulse <= 1'b0;
      req_no_gaps = 1'b1;
      for (int k = 0; k < 20; k++) begin
         if ($urandom_range(0, 1) == 0)
            read_frame($urandom_range(0, SLOTS - 1));
         else
            pop_frame($urandom_range(0, 63) - 32);
      end
      req_no_gaps = 1'b0;
   endtask

   // unconstrained commands under random settings
   task automatic test_random_mix();
      int stop_at;
      for (int phase = 0; phase < 5; phase++) begin
         write_csr(CSR_STACK_MODE, $urandom_range(0, 3));
         if (phase == 0)
            write_csr(CSR_STACK_LIMIT, 0);
         else if (phase == 1)
            write_csr(CSR_STACK_LIMIT, int'(LIMIT_RESET));
         else
            write_csr(CSR_STACK_LIMIT, $urandom_range(0, 31));
         stop_at = cmd_count + 30;
         while (cmd_count < stop_at)
            send_cmd(random_cmd());
      end
   endtask

   // result side: random ready, long hold on request, compare each transfer
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            $error("result word %0h arrived with nothing pending", rsp_ch.out_word);
            fault_count++;
         end else begin
            rsp_want = pending_words.pop_front();
            check_field("out_word", rsp_want.word, rsp_ch.out_word);
            check_field("out_index", DATA_W'(rsp_want.index), DATA_W'(rsp_ch.out_index));
            check_field("last_word", DATA_W'(rsp_want.last), DATA_W'(rsp_ch.last_word));
            check_field("stack_error", DATA_W'(rsp_want.error), DATA_W'(rsp_ch.stack_error));
            check_field("stack_pointer_out", DATA_W'(rsp_want.pointer),
                        DATA_W'(rsp_ch.stack_pointer_out));
         end
         rsp_wait = draw_gap(rsp_calm);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      if (stall_pulse)
         rsp_hold = STALL_CYCLES;
      else if (rsp_hold > 0)
         rsp_hold--;
      rsp_ch.ready <= !reset && rsp_wait == 0 && rsp_hold == 0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // sequence
   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.op          <= OP_PUSH;
      req_ch.word_index  <= '0;
      req_ch.word_value  <= '0;
      req_ch.pop_amount  <= '0;
      req_ch.slot_number <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_STACK_MODE;
      csr_ch.data        <= '0;
      stall_pulse        <= 1'b0;

      // shadow state after reset: identity everywhere, ones on words 0, 5, 10, 15
      for (int s = 0; s < SLOTS; s++)
         for (int w = 0; w < WORDS_PER_MATRIX; w++)
            shadow_mem[s * WORDS_PER_MATRIX + w] = (w % 5 == 0) ? ONE_BITS : '0;
      shadow_ptr   = '0;
      shadow_err   = 1'b0;
      shadow_mode  = MODE_RESET;
      shadow_limit = LIMIT_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_push_and_load();
      test_modes_and_limit();
      test_stack_frames();
      test_stack_errors();
      test_output_stall();
      test_random_mix();

      settle();
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ geometry_matrix_stack_core.f @@
+incdir+sv
sv/gmsk_pkg.sv
sv/gmsk_if.sv
sv/gmsk_store.sv
sv/gmsk_ctrl.sv
sv/geometry_matrix_stack_core.sv
tb/geometry_matrix_stack_core_tb.sv
